### hdl/spline_arc_length_assert.svh
// assertion macros for the spline arc length block
`ifndef SPLINE_ARC_LENGTH_ASSERT_SVH
`define SPLINE_ARC_LENGTH_ASSERT_SVH
// condition holds at every edge outside reset
`define SAL_ASSERT(lbl, cond, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
// condition in the cycle after a trigger
`define SAL_ASSERT_NEXT(lbl, pre, post, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);
`endif

### hdl/sal_pkg.sv
// types and constants shared by the spline arc length block
package sal_pkg;
	localparam int MAX_POINTS = 1024;
	localparam int CNT_W = $clog2(MAX_POINTS) + 1;
	localparam int NODE_W = 10;
	localparam int LEN_W = 40;
	localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};
	localparam logic [9:0] SEG_CNT_MAX = 10'd1023;
	localparam logic [15:0] STEP_RESET = 16'd655;
	localparam int ADDR_W = 3;
	localparam logic REG_STEP = 1'b0;
	localparam logic REG_SKIP = 1'b1;
	localparam int FIFO_DEPTH = 2;
	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int FCNT_W = $clog2(FIFO_DEPTH + 1);

	typedef struct packed {
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic final_point;
	} point_t;

	typedef struct packed {
		logic [NODE_W-1:0] segment_index;
		logic [LEN_W-1:0] seg_length;
		logic [LEN_W-1:0] running_length;
		logic [9:0] segment_count;
		logic overflow_error;
		logic last_result;
	} result_t;

	typedef struct packed {
		logic do_seg;
		logic [NODE_W-1:0] node;
		logic [1:0] trail_n;
		logic [NODE_W-1:0] trail_lo;
		logic fin;
		logic [3:0][31:0] px;
		logic [3:0][31:0] py;
	} cmd_t;
endpackage

### hdl/spline_arc_length.sv
// Arc length of a waypoint path along a cubic blend of four points, in Q16.16
// fixed point. A waypoint word that completes a segment or ends the path goes
// into a small command queue at once; other words only update the window. The
// back end then walks t from 0 in steps of step_size (a step of zero counts as
// one). For each sample it forms t squared and t cubed on the shared 33x33
// multiplier, builds the four weights, blends the points by multiply and
// accumulate and rounds; every sample after the first then squares the x and y
// steps from the last sample and takes a square root that retires two bits a
// cycle. A segment takes S = ceil(65536 / step_size) samples, one after another;
// each trailing zero-length word makes a result of its own, and result_stall
// can hold any result. A final word that makes no segment emits only those.
// Registers: step_size at byte address 0, skip_nodes at byte address 4.
module spline_arc_length (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [sal_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input  logic point_valid,
	output logic point_stall,
	input  sal_pkg::point_t point,
	output logic result_valid,
	input  logic result_stall,
	output sal_pkg::result_t result
);
	import sal_pkg::*;

	logic [15:0] step_q;
	logic [1:0] skip_q;
	logic cmd_push, cmd_pop, cmd_full, cmd_empty;
	cmd_t cmd_in, cmd_head;

	assign pready = 1'b1;

	always_comb begin
		unique case (paddr[2])
			REG_STEP: prdata = {16'd0, step_q};
			REG_SKIP: prdata = {30'd0, skip_q};
			default: prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_RESET;
			skip_q <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_STEP: step_q <= pwdata[15:0];
				REG_SKIP: skip_q <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	sal_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.point_valid(point_valid),
		.point_stall(point_stall),
		.point(point),
		.skip_nodes(skip_q),
		.cmd_full(cmd_full),
		.cmd_push(cmd_push),
		.cmd(cmd_in)
	);

	sal_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(cmd_push),
		.din(cmd_in),
		.pop(cmd_pop),
		.full(cmd_full),
		.empty(cmd_empty),
		.head(cmd_head)
	);

	sal_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.step_size(step_q),
		.cmd_valid(!cmd_empty),
		.cmd(cmd_head),
		.cmd_pop(cmd_pop),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);
endmodule

### hdl/sal_front.sv
// front end: waypoint window, point count and segment commands
module sal_front (
	input  logic clk,
	input  logic arst_n,
	input  logic point_valid,
	output logic point_stall,
	input  sal_pkg::point_t point,
	input  logic [1:0] skip_nodes,
	input  logic cmd_full,
	output logic cmd_push,
	output sal_pkg::cmd_t cmd
);
	import sal_pkg::*;

	logic [31:0] win_x_q [3];
	logic [31:0] win_y_q [3];
	logic [CNT_W-1:0] seen_q;
	logic accept, room, do_seg;
	logic [CNT_W-1:0] skip_w, n, lo_a, lo, hi, span;

	assign point_stall = cmd_full;
	assign accept = point_valid && !cmd_full;

	always_comb begin
		skip_w = CNT_W'(skip_nodes);
		room = seen_q < CNT_W'(MAX_POINTS);
		do_seg = room && (seen_q >= CNT_W'(3)) && ((seen_q - CNT_W'(3)) >= skip_w);
		n = room ? seen_q + CNT_W'(1) : seen_q;
		lo_a = (n >= CNT_W'(3)) ? n - CNT_W'(3) : '0;
		lo = (lo_a < skip_w) ? skip_w : lo_a;
		hi = (n > skip_w) ? n - skip_w : '0;
		span = (hi > lo) ? hi - lo : '0;
		cmd_push = accept && (do_seg || point.final_point);
		cmd.do_seg = do_seg;
		cmd.node = NODE_W'(seen_q - CNT_W'(3));
		cmd.trail_n = point.final_point ? span[1:0] : 2'd0;
		cmd.trail_lo = lo[NODE_W-1:0];
		cmd.fin = point.final_point;
		cmd.px = {point.point_x, win_x_q[2], win_x_q[1], win_x_q[0]};
		cmd.py = {point.point_y, win_y_q[2], win_y_q[1], win_y_q[0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
		end else if (accept) begin
			if (point.final_point) begin
				seen_q <= '0;
			end else if (room) begin
				seen_q <= seen_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && room) begin
			win_x_q[0] <= win_x_q[1];
			win_x_q[1] <= win_x_q[2];
			win_x_q[2] <= point.point_x;
			win_y_q[0] <= win_y_q[1];
			win_y_q[1] <= win_y_q[2];
			win_y_q[2] <= point.point_y;
		end
	end
endmodule

### hdl/sal_fifo.sv
// short command queue between front and back
module sal_fifo (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  sal_pkg::cmd_t din,
	input  logic pop,
	output logic full,
	output logic empty,
	output sal_pkg::cmd_t head
);
	import sal_pkg::*;

	cmd_t mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [FCNT_W-1:0] cnt_q;

	assign full = cnt_q == FCNT_W'(FIFO_DEPTH);
	assign empty = cnt_q == '0;
	assign head = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + PTR_W'(1);
			if (pop) rd_q <= rd_q + PTR_W'(1);
			if (push && !pop) cnt_q <= cnt_q + FCNT_W'(1);
			else if (pop && !push) cnt_q <= cnt_q - FCNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= din;
	end
endmodule

### hdl/sal_sqrt.sv
// iterative floor square root, two result bits per cycle
module sal_sqrt (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [63:0] value,
	output logic done,
	output logic [31:0] root
);
	logic busy_q, done_q;
	logic [3:0] cnt_q;
	logic [63:0] val_q;
	logic [33:0] rem_q;
	logic [31:0] root_q;
	logic [35:0] rem_a, trial_a, rem_a2, rem_b, trial_b, rem_b2;
	logic [31:0] root_a, root_b;
	logic ge_a, ge_b;

	always_comb begin
		rem_a = {rem_q, val_q[63:62]};
		trial_a = {2'b00, root_q, 2'b01};
		ge_a = rem_a >= trial_a;
		rem_a2 = ge_a ? rem_a - trial_a : rem_a;
		root_a = {root_q[30:0], ge_a};
		rem_b = {rem_a2[33:0], val_q[61:60]};
		trial_b = {2'b00, root_a, 2'b01};
		ge_b = rem_b >= trial_b;
		rem_b2 = ge_b ? rem_b - trial_b : rem_b;
		root_b = {root_a[30:0], ge_b};
	end

	assign done = done_q;
	assign root = root_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == 4'd15);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'd15) busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_q <= value;
			rem_q <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			val_q <= {val_q[59:0], 4'b0000};
			rem_q <= rem_b2[33:0];
			root_q <= root_b;
		end
	end
endmodule

### hdl/sal_back.sv
// back end: sample sequencer, shared multiplier, length totals and result word
module sal_back (
	input  logic clk,
	input  logic arst_n,
	input  logic [15:0] step_size,
	input  logic cmd_valid,
	input  sal_pkg::cmd_t cmd,
	output logic cmd_pop,
	output logic result_valid,
	input  logic result_stall,
	output sal_pkg::result_t result
);
	import sal_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_SQ, S_CUBE, S_WGT, S_BLEND, S_ROUND, S_DIFF,
		S_SQX, S_SQY, S_SUM, S_ROOT, S_ADV, S_EMIT, S_NEXT
	} state_t;

	state_t state_q;
	logic [15:0] t_q;
	logic first_q;
	logic [31:0] u2_q;
	logic signed [65:0] p_q;
	logic signed [31:0] w_q [4];
	logic [3:0] k_q;
	logic signed [65:0] acc_x_q, acc_y_q;
	logic signed [31:0] nx_q, ny_q, ox_q, oy_q;
	logic [31:0] ax_q, ay_q;
	logic [63:0] sq_x_q;
	logic [LEN_W-1:0] len_q, total_q, emit_len_q;
	logic [9:0] cnt_q;
	logic err_q;
	logic [NODE_W-1:0] emit_node_q, trail_node_q;
	logic [1:0] trail_left_q;
	logic emit_last_q;
	logic res_valid_q;
	result_t res_q;

	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] mul_p;
	logic [15:0] step_eff;
	logic [16:0] t_next;
	logic signed [51:0] u3s, u2s, uts, q0, q1, q2, q3;
	logic signed [65:0] rx, ry;
	logic signed [31:0] sat_x, sat_y;
	logic ov_x, ov_y;
	logic signed [32:0] dx, dy, adx, ady;
	logic [64:0] sq_sum;
	logic [63:0] sq_val;
	logic sq_ovf, sqrt_start, sqrt_done;
	logic [31:0] sqrt_root;
	logic [LEN_W:0] len_sum, tot_sum;
	logic [LEN_W-1:0] tot_new;
	logic [9:0] cnt_new;
	logic out_free;

	function automatic logic signed [31:0] rnd_w(input logic signed [51:0] q);
		logic signed [51:0] r;
		r = (q + 52'sd131072) >>> 18;
		return $signed(r[31:0]);
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		if (v > 66'sd2147483647) return 32'sh7fffffff;
		if (v < -66'sd2147483648) return $signed(32'h80000000);
		return $signed(v[31:0]);
	endfunction

	sal_sqrt u_sqrt (
		.clk(clk),
		.arst_n(arst_n),
		.start(sqrt_start),
		.value(sq_val),
		.done(sqrt_done),
		.root(sqrt_root)
	);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_SQ: begin
				mul_a = $signed({17'd0, t_q});
				mul_b = $signed({17'd0, t_q});
			end
			S_CUBE: begin
				mul_a = $signed({1'b0, p_q[31:0]});
				mul_b = $signed({17'd0, t_q});
			end
			S_BLEND: begin
				if (k_q[3] == 1'b0) begin
					mul_a = k_q[2] ? $signed({cmd.py[k_q[1:0]][31], cmd.py[k_q[1:0]]})
						: $signed({cmd.px[k_q[1:0]][31], cmd.px[k_q[1:0]]});
					mul_b = $signed({w_q[k_q[1:0]][31], w_q[k_q[1:0]]});
				end
			end
			S_SQX: begin
				mul_a = $signed({1'b0, ax_q});
				mul_b = $signed({1'b0, ax_q});
			end
			S_SQY: begin
				mul_a = $signed({1'b0, ay_q});
				mul_b = $signed({1'b0, ay_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		mul_p = mul_a * mul_b;
		step_eff = (step_size == 16'd0) ? 16'd1 : step_size;
		t_next = {1'b0, t_q} + {1'b0, step_eff};
		u3s = $signed({4'd0, p_q[47:0]});
		u2s = $signed({4'd0, u2_q, 16'd0});
		uts = $signed({4'd0, t_q, 32'd0});
		q0 = (u3s <<< 1) - (u2s + (u2s <<< 1)) + $signed(52'h1_0000_0000_0000);
		q1 = u3s - (u2s <<< 1) + uts;
		q2 = (u2s + (u2s <<< 1)) - (u3s <<< 1);
		q3 = u3s - u2s;
		rx = (acc_x_q + 66'sd536870912) >>> 30;
		ry = (acc_y_q + 66'sd536870912) >>> 30;
		sat_x = sat32(rx);
		sat_y = sat32(ry);
		ov_x = (rx > 66'sd2147483647) || (rx < -66'sd2147483648);
		ov_y = (ry > 66'sd2147483647) || (ry < -66'sd2147483648);
		dx = $signed({nx_q[31], nx_q}) - $signed({ox_q[31], ox_q});
		dy = $signed({ny_q[31], ny_q}) - $signed({oy_q[31], oy_q});
		adx = dx[32] ? -dx : dx;
		ady = dy[32] ? -dy : dy;
		sq_sum = {1'b0, sq_x_q} + {1'b0, p_q[63:0]};
		sq_ovf = sq_sum[64];
		sq_val = sq_ovf ? {64{1'b1}} : sq_sum[63:0];
		sqrt_start = state_q == S_SUM;
		len_sum = {1'b0, len_q} + (LEN_W + 1)'(sqrt_root);
		tot_sum = {1'b0, total_q} + {1'b0, emit_len_q};
		tot_new = tot_sum[LEN_W] ? LEN_MAX : tot_sum[LEN_W-1:0];
		cnt_new = ((emit_len_q != '0) && (cnt_q != SEG_CNT_MAX)) ? cnt_q + 10'd1 : cnt_q;
		out_free = !res_valid_q || !result_stall;
		cmd_pop = (state_q == S_NEXT) && (trail_left_q == 2'd0);
	end

	assign result_valid = res_valid_q;
	assign result = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			res_valid_q <= 1'b0;
			total_q <= '0;
			cnt_q <= '0;
			err_q <= 1'b0;
			k_q <= '0;
			first_q <= 1'b0;
			trail_left_q <= '0;
		end else begin
			if (res_valid_q && !result_stall && (state_q != S_EMIT)) res_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						trail_left_q <= cmd.trail_n;
						trail_node_q <= cmd.trail_lo;
						t_q <= '0;
						first_q <= 1'b1;
						len_q <= '0;
						state_q <= cmd.do_seg ? S_SQ : S_NEXT;
					end
				end
				S_SQ: begin
					p_q <= mul_p;
					state_q <= S_CUBE;
				end
				S_CUBE: begin
					u2_q <= p_q[31:0];
					p_q <= mul_p;
					state_q <= S_WGT;
				end
				S_WGT: begin
					w_q[0] <= rnd_w(q0);
					w_q[1] <= rnd_w(q1);
					w_q[2] <= rnd_w(q2);
					w_q[3] <= rnd_w(q3);
					k_q <= '0;
					state_q <= S_BLEND;
				end
				S_BLEND: begin
					p_q <= mul_p;
					if (k_q == 4'd0) begin
						acc_x_q <= '0;
						acc_y_q <= '0;
					end else if (k_q <= 4'd4) begin
						acc_x_q <= acc_x_q + p_q;
					end else begin
						acc_y_q <= acc_y_q + p_q;
					end
					k_q <= k_q + 4'd1;
					if (k_q == 4'd8) state_q <= S_ROUND;
				end
				S_ROUND: begin
					if (ov_x || ov_y) err_q <= 1'b1;
					nx_q <= sat_x;
					ny_q <= sat_y;
					if (first_q) begin
						ox_q <= sat_x;
						oy_q <= sat_y;
						state_q <= S_ADV;
					end else begin
						state_q <= S_DIFF;
					end
				end
				S_DIFF: begin
					ax_q <= adx[31:0];
					ay_q <= ady[31:0];
					ox_q <= nx_q;
					oy_q <= ny_q;
					state_q <= S_SQX;
				end
				S_SQX: begin
					p_q <= mul_p;
					state_q <= S_SQY;
				end
				S_SQY: begin
					sq_x_q <= p_q[63:0];
					p_q <= mul_p;
					state_q <= S_SUM;
				end
				S_SUM: begin
					if (sq_ovf) err_q <= 1'b1;
					state_q <= S_ROOT;
				end
				S_ROOT: begin
					if (sqrt_done) begin
						if (len_sum[LEN_W]) begin
							len_q <= LEN_MAX;
							err_q <= 1'b1;
						end else begin
							len_q <= len_sum[LEN_W-1:0];
						end
						state_q <= S_ADV;
					end
				end
				S_ADV: begin
					first_q <= 1'b0;
					if (t_next[16]) begin
						emit_len_q <= len_q;
						emit_node_q <= cmd.node;
						emit_last_q <= cmd.fin && (cmd.trail_n == 2'd0);
						state_q <= S_EMIT;
					end else begin
						t_q <= t_next[15:0];
						state_q <= S_SQ;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						total_q <= tot_new;
						cnt_q <= cnt_new;
						if (tot_sum[LEN_W]) err_q <= 1'b1;
						res_q.segment_index <= emit_node_q;
						res_q.seg_length <= emit_len_q;
						res_q.running_length <= tot_new;
						res_q.segment_count <= cnt_new;
						res_q.overflow_error <= err_q || tot_sum[LEN_W];
						res_q.last_result <= emit_last_q;
						res_valid_q <= 1'b1;
						state_q <= S_NEXT;
					end
				end
				S_NEXT: begin
					if (trail_left_q != 2'd0) begin
						emit_len_q <= '0;
						emit_node_q <= trail_node_q;
						emit_last_q <= cmd.fin && (trail_left_q == 2'd1);
						trail_left_q <= trail_left_q - 2'd1;
						trail_node_q <= trail_node_q + NODE_W'(1);
						state_q <= S_EMIT;
					end else begin
						if (cmd.fin) begin
							total_q <= '0;
							cnt_q <= '0;
							err_q <= 1'b0;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

### hdl/sal_checker.sv
// port checks for the spline arc length block
`include "spline_arc_length_assert.svh"
module sal_checker (
	input logic clk,
	input logic arst_n,
	input logic pready,
	input logic result_valid,
	input logic result_stall,
	input sal_pkg::result_t result
);
	`SAL_ASSERT(a_pready, pready, "pready dropped")
	`SAL_ASSERT(a_total, !result_valid || result.running_length >= result.seg_length, "total below segment")
	`SAL_ASSERT(a_count, !result_valid || result.seg_length == 0 || result.segment_count != 0, "count missing")
	`SAL_ASSERT_NEXT(a_hold, result_valid && result_stall, result_valid && $stable(result), "stalled word changed")
endmodule

bind spline_arc_length sal_checker u_checker (.*);
